[sv/tail_light_mode_and_pattern_controller_unit_macros.svh]
// Assertion macros shared by the checker of the tail light controller.
// No dependencies; included by sv/tlmp_checker.sv.
`ifndef TAIL_LIGHT_MODE_AND_PATTERN_CONTROLLER_UNIT_MACROS_SVH
`define TAIL_LIGHT_MODE_AND_PATTERN_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TLMP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define TLMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/tlmp_pkg.sv]
// Shared types, constants and tables for the tail light mode and pattern controller.
// No dependencies; used by tlmp_pattern, tlmp_state and the top level.
`timescale 1ns / 1ps

package tlmp_pkg;

   localparam int MODE_COUNT           = 15;
   localparam int HALFSECOND_MS_DEFAULT = 500;
   localparam logic [1:0] LOW_READINGS_TO_ACT = 2'd3;

   // event codes
   localparam logic [1:0] OP_POWER_UP = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_READING  = 2'd2;
   localparam logic [1:0] OP_NONE     = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_LOW_THRESHOLD  = 2'd0;
   localparam logic [1:0] CSR_CRIT_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_LOCK_HALFSEC   = 2'd2;
   localparam logic [1:0] CSR_PHASE_BELOW    = 2'd3;

   localparam logic [7:0] LOW_THRESHOLD_RST  = 8'd130;
   localparam logic [7:0] CRIT_THRESHOLD_RST = 8'd120;
   localparam logic [7:0] LOCK_HALFSEC_RST   = 8'd6;
   localparam logic [7:0] PHASE_BELOW_RST    = 8'd10;

   // mode values with a pattern of their own
   localparam logic [7:0] MV_READOUT     = 8'd254;
   localparam logic [7:0] MV_HEARTBEAT   = 8'd253;
   localparam logic [7:0] MV_RAMP_SLOW   = 8'd252;
   localparam logic [7:0] MV_RAMP_FAST   = 8'd251;
   localparam logic [7:0] MV_STROBE_SLOW = 8'd82;
   localparam logic [7:0] MV_STROBE_MID  = 8'd41;
   localparam logic [7:0] MV_STROBE_FAST = 8'd15;
   localparam logic [7:0] MV_BIKE_LAST   = 8'd2;

   localparam logic [7:0] BLINK_LEVEL = 8'd39;
   localparam logic [7:0] FULL_LEVEL  = 8'd255;

   localparam logic [3:0]  SEG_HOLD  = 4'd15;
   localparam logic [11:0] HOLD_MS   = 12'd1000;
   localparam logic [11:0] SOLID_MS  = 12'd500;

   localparam logic [6:0] RAMP_SLOW_STEPS = 7'd66;
   localparam logic [6:0] RAMP_SLOW_BASE  = 7'd27;
   localparam logic [6:0] RAMP_FAST_STEPS = 7'd100;
   localparam logic [6:0] RAMP_FAST_BASE  = 7'd9;

   typedef struct packed {
      logic [7:0] low_thr;
      logic [7:0] crit_thr;
      logic [7:0] lock_hs;
      logic [7:0] phase_below;
   } cfg_type;

   typedef struct packed {
      logic [7:0] value;
      logic [3:0] seg;
      logic [6:0] rep;
      logic [7:0] readout;
   } seg_ctx_type;

   typedef struct packed {
      logic [7:0]  level;
      logic [11:0] dur;
      logic [3:0]  seg_next;
      logic [6:0]  rep_next;
      logic        pass_end;
   } seg_plan_type;

   typedef struct packed {
      logic [7:0] pwm_level;
      logic       phase_correct;
      logic [3:0] mode_now;
      logic       is_locked;
      logic       powered_down;
   } status_type;

   // mode index to pattern value; out-of-range index runs as mode 0
   function automatic logic [7:0] mode_value(input logic [3:0] idx);
      logic [7:0] v;
      unique case (idx)
         4'd0:    v = MV_READOUT;
         4'd1:    v = MV_HEARTBEAT;
         4'd2:    v = 8'd0;
         4'd3:    v = 8'd1;
         4'd4:    v = 8'd2;
         4'd5:    v = 8'd4;
         4'd6:    v = 8'd14;
         4'd7:    v = 8'd39;
         4'd8:    v = 8'd120;
         4'd9:    v = 8'd255;
         4'd10:   v = MV_STROBE_SLOW;
         4'd11:   v = MV_STROBE_MID;
         4'd12:   v = MV_STROBE_FAST;
         4'd13:   v = MV_RAMP_SLOW;
         4'd14:   v = MV_RAMP_FAST;
         default: v = MV_READOUT;
      endcase
      return v;
   endfunction

   function automatic logic [11:0] readout_dur(input logic [3:0] seg);
      logic [11:0] d;
      unique case (seg)
         4'd0:    d = 12'd200;
         4'd1:    d = 12'd62;
         4'd2:    d = 12'd248;
         4'd3:    d = 12'd500;
         4'd4:    d = 12'd5;
         4'd5:    d = 12'd20;
         4'd6:    d = 12'd750;
         4'd7:    d = 12'd62;
         4'd8:    d = 12'd248;
         4'd9:    d = 12'd2000;
         default: d = 12'd1;
      endcase
      return d;
   endfunction

   function automatic logic [11:0] heartbeat_dur(input logic [1:0] seg);
      logic [11:0] d;
      unique case (seg)
         2'd0: d = 12'd1;
         2'd1: d = 12'd249;
         2'd2: d = 12'd1;
         2'd3: d = 12'd749;
      endcase
      return d;
   endfunction

endpackage

[sv/tlmp_pattern.sv]
// Pattern decoder: level and length of the current segment and the segment that follows.
// Depends on tlmp_pkg.
`timescale 1ns / 1ps

module tlmp_pattern (
   input  tlmp_pkg::seg_ctx_type  ctx,
   output tlmp_pkg::seg_plan_type plan
);

   // battery readout segments
   localparam logic [3:0] RO_LEAD      = 4'd0;
   localparam logic [3:0] RO_VOLT_ON   = 4'd1;
   localparam logic [3:0] RO_VOLT_OFF  = 4'd2;
   localparam logic [3:0] RO_GAP       = 4'd3;
   localparam logic [3:0] RO_DOT_ON    = 4'd4;
   localparam logic [3:0] RO_DOT_OFF   = 4'd5;
   localparam logic [3:0] RO_GAP2      = 4'd6;
   localparam logic [3:0] RO_TENTH_ON  = 4'd7;
   localparam logic [3:0] RO_TENTH_OFF = 4'd8;
   localparam logic [3:0] RO_TAIL      = 4'd9;
   localparam logic [3:0] RO_COUNT     = 4'd10;

   // generic on, off and rest segments of the short patterns, and their limits
   localparam logic [3:0] SEG_ON   = 4'd0;
   localparam logic [3:0] SEG_OFF  = 4'd1;
   localparam logic [3:0] SEG_REST = 4'd2;
   localparam logic [3:0] HB_LAST  = 4'd3;
   localparam logic [6:0] BIKE_REPEATS = 7'd4;

   localparam logic [6:0] RAMP_SLOW_HALF = tlmp_pkg::RAMP_SLOW_STEPS / 2;
   localparam logic [6:0] RAMP_FAST_HALF = tlmp_pkg::RAMP_FAST_STEPS / 2;

   logic [6:0] rep_inc, rep_dec;
   logic [6:0] ramp_slow, ramp_fast;
   logic [3:0] bike_lo_idx, bike_hi_idx;
   logic       is_strobe;

   assign rep_inc = ctx.rep + 7'd1;
   assign rep_dec = (ctx.rep != 7'd0) ? ctx.rep - 7'd1 : 7'd0;

   assign ramp_slow = (ctx.rep < RAMP_SLOW_HALF) ? ctx.rep : tlmp_pkg::RAMP_SLOW_STEPS - ctx.rep;
   assign ramp_fast = (ctx.rep < RAMP_FAST_HALF) ? ctx.rep : tlmp_pkg::RAMP_FAST_STEPS - ctx.rep;

   assign bike_lo_idx = 4'd5 + {2'b00, ctx.value[1:0]};
   assign bike_hi_idx = 4'd7 + {2'b00, ctx.value[1:0]};

   assign is_strobe = (ctx.value == tlmp_pkg::MV_STROBE_SLOW) ||
                      (ctx.value == tlmp_pkg::MV_STROBE_MID)  ||
                      (ctx.value == tlmp_pkg::MV_STROBE_FAST);

   always_comb begin
      plan.level    = 8'd0;
      plan.dur      = 12'd1;
      plan.seg_next = ctx.seg;
      plan.rep_next = ctx.rep;
      plan.pass_end = 1'b0;

      priority if (ctx.value == tlmp_pkg::MV_READOUT) begin
         if (ctx.seg < RO_COUNT) begin
            plan.dur = tlmp_pkg::readout_dur(ctx.seg);
         end
         if (ctx.seg == RO_VOLT_ON || ctx.seg == RO_DOT_ON || ctx.seg == RO_TENTH_ON) begin
            plan.level = tlmp_pkg::BLINK_LEVEL;
         end
         priority case (ctx.seg)
            RO_LEAD: begin
               // volts digit: a zero count skips its blinks
               if (ctx.readout[7:5] != 3'd0) begin
                  plan.seg_next = RO_VOLT_ON;
                  plan.rep_next = {4'd0, ctx.readout[7:5]};
               end else begin
                  plan.seg_next = RO_GAP;
               end
            end
            RO_GAP2: begin
               if (ctx.readout[4:0] != 5'd0) begin
                  plan.seg_next = RO_TENTH_ON;
                  plan.rep_next = {2'd0, ctx.readout[4:0]};
               end else begin
                  plan.seg_next = RO_TAIL;
               end
            end
            RO_VOLT_ON, RO_GAP, RO_DOT_ON, RO_DOT_OFF, RO_TENTH_ON: begin
               plan.seg_next = ctx.seg + 4'd1;
            end
            RO_VOLT_OFF, RO_TENTH_OFF: begin
               plan.rep_next = rep_dec;
               plan.seg_next = (rep_dec != 7'd0) ? ctx.seg - 4'd1 : ctx.seg + 4'd1;
            end
            default: begin
               plan.pass_end = 1'b1;
            end
         endcase
      end else if (ctx.value == tlmp_pkg::MV_HEARTBEAT) begin
         if (ctx.seg <= HB_LAST) begin
            plan.dur   = tlmp_pkg::heartbeat_dur(ctx.seg[1:0]);
            plan.level = ctx.seg[0] ? 8'd0 : tlmp_pkg::FULL_LEVEL;
         end
         if (ctx.seg < HB_LAST) begin
            plan.seg_next = ctx.seg + 4'd1;
         end else begin
            plan.pass_end = 1'b1;
         end
      end else if (ctx.value <= tlmp_pkg::MV_BIKE_LAST) begin
         priority if (ctx.seg == SEG_ON) begin
            plan.level    = tlmp_pkg::mode_value(bike_hi_idx);
            plan.dur      = 12'd5;
            plan.seg_next = SEG_OFF;
         end else if (ctx.seg == SEG_OFF) begin
            plan.level    = tlmp_pkg::mode_value(bike_lo_idx);
            plan.dur      = 12'd65;
            plan.rep_next = rep_inc;
            plan.seg_next = (rep_inc < BIKE_REPEATS) ? SEG_ON : SEG_REST;
         end else begin
            plan.level    = tlmp_pkg::mode_value(bike_lo_idx);
            plan.dur      = 12'd720;
            plan.pass_end = 1'b1;
         end
      end else if (is_strobe) begin
         if (ctx.seg == SEG_ON) begin
            plan.level    = tlmp_pkg::FULL_LEVEL;
            plan.seg_next = SEG_OFF;
         end else begin
            plan.dur      = {4'd0, ctx.value};
            plan.pass_end = 1'b1;
         end
      end else if (ctx.value == tlmp_pkg::MV_RAMP_SLOW ||
                   ctx.value == tlmp_pkg::MV_RAMP_FAST) begin
         if (ctx.seg == SEG_ON) begin
            plan.level    = tlmp_pkg::FULL_LEVEL;
            plan.seg_next = SEG_OFF;
         end else begin
            if (ctx.value == tlmp_pkg::MV_RAMP_SLOW) begin
               plan.dur = {4'd0, 7'(ramp_slow + tlmp_pkg::RAMP_SLOW_BASE), 1'b0};
            end else begin
               plan.dur = {5'd0, 7'(ramp_fast + tlmp_pkg::RAMP_FAST_BASE)};
            end
            plan.rep_next = rep_inc;
            if (ctx.seg == SEG_OFF &&
                rep_inc < ((ctx.value == tlmp_pkg::MV_RAMP_SLOW) ?
                           tlmp_pkg::RAMP_SLOW_STEPS : tlmp_pkg::RAMP_FAST_STEPS)) begin
               plan.seg_next = SEG_ON;
            end else begin
               plan.pass_end = 1'b1;
            end
         end
      end else begin
         // solid level, one fixed-length pass
         plan.level    = ctx.value;
         plan.dur      = tlmp_pkg::SOLID_MS;
         plan.pass_end = 1'b1;
      end
   end

endmodule

[sv/tlmp_state.sv]
// Controller state: mode selection, lock timer, segment sequencing and battery checks.
// Depends on tlmp_pkg and tlmp_pattern.
`timescale 1ns / 1ps

module tlmp_state #(
   parameter int HALFSECOND_MS = tlmp_pkg::HALFSECOND_MS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [1:0]           op,
   input  logic                 short_press,
   input  logic [7:0]           adc_value,
   input  logic [7:0]           readout_code,
   input  tlmp_pkg::cfg_type    cfg,
   output tlmp_pkg::status_type status
);

   localparam int MsWidth = (HALFSECOND_MS > 1) ? $clog2(HALFSECOND_MS) : 1;
   localparam logic [MsWidth-1:0] MsLast = MsWidth'(HALFSECOND_MS - 1);
   localparam logic [3:0] ModeLast = 4'(tlmp_pkg::MODE_COUNT - 1);

   logic [3:0]         rem_mode_ff, rem_mode_in;
   logic               lock_ff, lock_in;
   logic [3:0]         run_mode_ff, run_mode_in;
   logic [MsWidth-1:0] ms_ff, ms_in;
   logic [7:0]         hs_cnt_ff, hs_cnt_in;
   logic [3:0]         seg_ff, seg_in;
   logic [6:0]         rep_ff, rep_in;
   logic [11:0]        timer_ff, timer_in;
   logic [1:0]         low_cnt_ff, low_cnt_in;
   logic               pending_ff, pending_in;
   logic [7:0]         adc_ff, adc_in;
   logic [7:0]         readout_ff, readout_in;
   logic               pwm_kind_ff, pwm_kind_in;
   logic               shutdown_ff, shutdown_in;
   logic [7:0]         level_ff, level_in;

   tlmp_pkg::seg_ctx_type  ctx;
   tlmp_pkg::seg_plan_type plan;

   logic [3:0]  resume_mode, wake_mode;
   logic [7:0]  hs_sat;
   logic        in_hold;
   logic [11:0] seg_dur, timer_inc;
   logic [7:0]  thr;
   logic [1:0]  low_next;

   assign ctx.value   = tlmp_pkg::mode_value(run_mode_ff);
   assign ctx.seg     = seg_ff;
   assign ctx.rep     = rep_ff;
   assign ctx.readout = readout_ff;

   tlmp_pattern u_pattern (
      .ctx  (ctx),
      .plan (plan)
   );

   // mode picked by a power-up event
   assign resume_mode = (rem_mode_ff <= ModeLast) ? rem_mode_ff : 4'd0;
   always_comb begin
      wake_mode = resume_mode;
      if (!lock_ff) begin
         wake_mode = (resume_mode >= ModeLast) ? 4'd0 : resume_mode + 4'd1;
      end
      if (!short_press) begin
         wake_mode = 4'd0;
      end
   end

   assign hs_sat    = (hs_cnt_ff == 8'hFF) ? hs_cnt_ff : hs_cnt_ff + 8'd1;
   assign in_hold   = (seg_ff == tlmp_pkg::SEG_HOLD);
   assign seg_dur   = in_hold ? tlmp_pkg::HOLD_MS : plan.dur;
   assign timer_inc = timer_ff + 12'd1;
   assign thr       = (run_mode_ff == 4'd0) ? cfg.crit_thr : cfg.low_thr;
   assign low_next  = (adc_ff < thr) ?
                      ((low_cnt_ff == 2'd3) ? low_cnt_ff : low_cnt_ff + 2'd1) : 2'd0;

   always_comb begin
      rem_mode_in = rem_mode_ff;
      lock_in     = lock_ff;
      run_mode_in = run_mode_ff;
      ms_in       = ms_ff;
      hs_cnt_in   = hs_cnt_ff;
      seg_in      = seg_ff;
      rep_in      = rep_ff;
      timer_in    = timer_ff;
      low_cnt_in  = low_cnt_ff;
      pending_in  = pending_ff;
      adc_in      = adc_ff;
      readout_in  = readout_ff;
      pwm_kind_in = pwm_kind_ff;
      shutdown_in = shutdown_ff;
      level_in    = level_ff;

      if (fire) begin
         unique case (op)
            tlmp_pkg::OP_POWER_UP: begin
               rem_mode_in = wake_mode;
               run_mode_in = wake_mode;
               if (!short_press) begin
                  lock_in = 1'b0;
               end
               pwm_kind_in = (tlmp_pkg::mode_value(wake_mode) < cfg.phase_below);
               ms_in       = '0;
               hs_cnt_in   = 8'd0;
               seg_in      = 4'd0;
               rep_in      = 7'd0;
               timer_in    = 12'd0;
               low_cnt_in  = 2'd0;
               pending_in  = 1'b0;
               shutdown_in = 1'b0;
               level_in    = 8'd0;
            end
            tlmp_pkg::OP_READING: begin
               adc_in     = adc_value;
               readout_in = readout_code;
               pending_in = 1'b1;
            end
            tlmp_pkg::OP_TICK: begin
               if (!shutdown_ff) begin
                  // lock timer runs only until the lock engages
                  if (!lock_ff) begin
                     if (ms_ff == MsLast) begin
                        ms_in     = '0;
                        hs_cnt_in = hs_sat;
                        if (hs_sat >= cfg.lock_hs) begin
                           lock_in = 1'b1;
                        end
                     end else begin
                        ms_in = ms_ff + MsWidth'(1);
                     end
                  end
                  // step-down hold keeps the last level
                  if (!in_hold) begin
                     level_in = plan.level;
                  end
                  if (timer_inc >= seg_dur) begin
                     timer_in = 12'd0;
                     if (in_hold) begin
                        seg_in = 4'd0;
                        rep_in = 7'd0;
                     end else if (!plan.pass_end) begin
                        seg_in = plan.seg_next;
                        rep_in = plan.rep_next;
                     end else begin
                        seg_in = 4'd0;
                        rep_in = 7'd0;
                        if (pending_ff) begin
                           pending_in = 1'b0;
                           if (low_next >= tlmp_pkg::LOW_READINGS_TO_ACT) begin
                              low_cnt_in = 2'd0;
                              if (run_mode_ff != 4'd0) begin
                                 run_mode_in = 4'd0;
                                 seg_in      = tlmp_pkg::SEG_HOLD;
                              end else begin
                                 shutdown_in = 1'b1;
                                 level_in    = 8'd0;
                              end
                           end else begin
                              low_cnt_in = low_next;
                           end
                        end
                     end
                  end else begin
                     timer_in = timer_inc;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_mode_ff <= 4'd0;
         lock_ff     <= 1'b0;
         run_mode_ff <= 4'd0;
         ms_ff       <= '0;
         hs_cnt_ff   <= 8'd0;
         seg_ff      <= 4'd0;
         rep_ff      <= 7'd0;
         timer_ff    <= 12'd0;
         low_cnt_ff  <= 2'd0;
         pending_ff  <= 1'b0;
         adc_ff      <= 8'd0;
         readout_ff  <= 8'd0;
         pwm_kind_ff <= 1'b0;
         shutdown_ff <= 1'b0;
         level_ff    <= 8'd0;
      end else begin
         rem_mode_ff <= rem_mode_in;
         lock_ff     <= lock_in;
         run_mode_ff <= run_mode_in;
         ms_ff       <= ms_in;
         hs_cnt_ff   <= hs_cnt_in;
         seg_ff      <= seg_in;
         rep_ff      <= rep_in;
         timer_ff    <= timer_in;
         low_cnt_ff  <= low_cnt_in;
         pending_ff  <= pending_in;
         adc_ff      <= adc_in;
         readout_ff  <= readout_in;
         pwm_kind_ff <= pwm_kind_in;
         shutdown_ff <= shutdown_in;
         level_ff    <= level_in;
      end
   end

   assign status.pwm_level     = shutdown_in ? 8'd0 : level_in;
   assign status.phase_correct = pwm_kind_in;
   assign status.mode_now      = run_mode_in;
   assign status.is_locked     = lock_in;
   assign status.powered_down  = shutdown_in;

endmodule

[sv/tail_light_mode_and_pattern_controller_unit.sv]
// Path: an accepted word goes into the input register, then into the result register,
// which drives rsp_*. Throughput: one word per cycle while rsp_stall is low; while a
// finished result waits on rsp_stall, the input register holds one more word and req_stall rises.
// Reset (synchronous, active high): controller state clears, mode 0, unlocked, and
// the thresholds return to 130 / 120, lock after 6 half-seconds, phase-correct below 10.
`timescale 1ns / 1ps

// Top level of the tail light mode and pattern controller.
// Depends on tlmp_pkg and tlmp_state (which holds tlmp_pattern).
module tail_light_mode_and_pattern_controller_unit #(
   parameter int HALFSECOND_MS = tlmp_pkg::HALFSECOND_MS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // input events
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic       req_short_press,
   input  logic [7:0] req_adc_value,
   input  logic [7:0] req_readout_code,
   // per-event status word
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_pwm_level,
   output logic       rsp_phase_correct,
   output logic [3:0] rsp_mode_now,
   output logic       rsp_is_locked,
   output logic       rsp_powered_down,
   // register writes
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   // Input register: holds one event word until the result register has room.
   logic       in_valid_ff, in_valid_in;
   logic [1:0] op_ff;
   logic       short_ff;
   logic [7:0] adc_ff;
   logic [7:0] readout_ff;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   tlmp_pkg::status_type rsp_ff;
   tlmp_pkg::status_type status;

   tlmp_pkg::cfg_type cfg_ff, cfg_in;

   logic req_take;
   logic advance;

   // The event in the input register is processed (and the state updated) in the
   // cycle it moves into the result register; the next event already sees it.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= req_op;
         short_ff   <= req_short_press;
         adc_ff     <= req_adc_value;
         readout_ff <= req_readout_code;
      end
      if (advance) begin
         rsp_ff <= status;
      end
   end

   // Configuration registers; the user must write them only while the block is quiet (not enforced here).
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tlmp_pkg::CSR_LOW_THRESHOLD:  cfg_in.low_thr     = csr_data;
            tlmp_pkg::CSR_CRIT_THRESHOLD: cfg_in.crit_thr    = csr_data;
            tlmp_pkg::CSR_LOCK_HALFSEC:   cfg_in.lock_hs     = csr_data;
            tlmp_pkg::CSR_PHASE_BELOW:    cfg_in.phase_below = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_thr     <= tlmp_pkg::LOW_THRESHOLD_RST;
         cfg_ff.crit_thr    <= tlmp_pkg::CRIT_THRESHOLD_RST;
         cfg_ff.lock_hs     <= tlmp_pkg::LOCK_HALFSEC_RST;
         cfg_ff.phase_below <= tlmp_pkg::PHASE_BELOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // All per-event work: mode pick, lock timer, segment step, battery judgment.
   tlmp_state #(
      .HALFSECOND_MS (HALFSECOND_MS)
   ) u_state (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .op           (op_ff),
      .short_press  (short_ff),
      .adc_value    (adc_ff),
      .readout_code (readout_ff),
      .cfg          (cfg_ff),
      .status       (status)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pwm_level     = rsp_ff.pwm_level;
   assign rsp_phase_correct = rsp_ff.phase_correct;
   assign rsp_mode_now      = rsp_ff.mode_now;
   assign rsp_is_locked     = rsp_ff.is_locked;
   assign rsp_powered_down  = rsp_ff.powered_down;

endmodule

[sv/tlmp_checker.sv]
// Port-level checks for the tail light controller, bound to the top level.
// Depends on tail_light_mode_and_pattern_controller_unit_macros.svh.
`timescale 1ns / 1ps
`include "tail_light_mode_and_pattern_controller_unit_macros.svh"

module tlmp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_pwm_level,
   input logic [3:0] rsp_mode_now,
   input logic       rsp_is_locked,
   input logic       rsp_powered_down
);

   `TLMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pwm_level) && $stable(rsp_mode_now), "stalled word changed")
   `TLMP_ASSERT_NOW(a_down_dark, clock, reset, rsp_valid && rsp_powered_down, rsp_pwm_level == 8'd0, "light on after shutdown")
   `TLMP_ASSERT_NOW(a_mode_range, clock, reset, rsp_valid, rsp_mode_now != 4'd15, "mode index out of range")
   `TLMP_ASSERT_NEXT(a_no_stall_when_empty, clock, reset, !req_valid && !rsp_valid, !req_stall, "input stalled with nothing in flight")

endmodule

bind tail_light_mode_and_pattern_controller_unit tlmp_checker u_tlmp_checker (.*);
